// ===== src/rws_pkg.sv =====
// Shared types and constants for the roulette wheel selection block.
// Item structs, function codes and datapath control bundle; no dependencies.
package rws_pkg;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  // Raw Q1.15 value of -1.0; also the bit that turns a fitness into its weight.
  localparam logic [15:0] FIT_RESET = 16'h8000;

  typedef struct packed {
    logic               func;
    logic [3:0]         slot;
    logic signed [15:0] fitness;
    logic [15:0]        rand_fraction;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         chosen_slot;
    logic [3:0]         best_slot;
    logic signed [15:0] best_fitness;
    logic               write_rejected;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic sum_en;
    logic mul_en;
    logic pick_en;
  } dp_ctl_t;

endpackage

// ===== src/roulette_wheel_selection.sv =====
// Roulette wheel selection: fitness table, scan sequencer and shared datapath.
// Write item: result strobe in the cycle after accept, busy never rises.
// Select item: busy while the single table read port is scanned twice over the
// n active slots; result strobe in the same cycle that busy falls.
// Reset: all slots read -1.0, pop_size is 10. Results cannot be stalled.
// Depends on rws_pkg, rws_table and rws_dp.
module roulette_wheel_selection #(
  parameter int MAX_POPULATION = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rws_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rws_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);

  localparam int IW = $clog2(MAX_POPULATION);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM_RD,
    S_SUM_END,
    S_MUL,
    S_PICK_RD,
    S_PICK_END,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               cons_r, cons_nxt;
  logic               cons_sum_r, cons_sum_nxt;
  logic [IW-1:0]      cons_idx_r, cons_idx_nxt;
  logic [15:0]        frac_r, frac_nxt;
  logic               out_valid_r, out_valid_nxt;
  rws_pkg::out_item_t out_item_r, out_item_nxt;
  logic [4:0]         pop_size_r;

  logic [4:0]         n_w;
  logic [IW-1:0]      last_w;
  logic               rejected_w;
  logic               accept_w;
  logic               we_w;
  rws_pkg::dp_ctl_t   ctl_w;
  logic [15:0]        rdata_w;
  logic               found_w;
  logic [IW-1:0]      chosen_idx_w;
  logic [IW-1:0]      best_idx_w;
  logic signed [15:0] best_fit_w;

  always_comb begin
    if (pop_size_r == 5'd0) begin
      n_w = 5'd1;
    end else if (32'(pop_size_r) > MAX_POPULATION) begin
      n_w = 5'(MAX_POPULATION);
    end else begin
      n_w = pop_size_r;
    end
  end

  assign last_w     = IW'(n_w - 5'd1);
  assign rejected_w = {1'b0, in_item.slot} >= n_w;
  assign accept_w   = start && (state_r == S_IDLE);
  assign we_w       = accept_w && (in_item.func == rws_pkg::FUNC_WRITE) && !rejected_w;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cons_nxt      = 1'b0;
    cons_sum_nxt  = cons_sum_r;
    cons_idx_nxt  = cons_idx_r;
    frac_nxt      = frac_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ctl_w         = '0;
    ctl_w.sum_en  = cons_r && cons_sum_r;
    ctl_w.pick_en = cons_r && !cons_sum_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          frac_nxt = in_item.rand_fraction;
          if (in_item.func == rws_pkg::FUNC_WRITE) begin
            out_item_nxt.chosen_slot    = '0;
            out_item_nxt.best_slot      = '0;
            out_item_nxt.best_fitness   = '0;
            out_item_nxt.write_rejected = rejected_w;
            out_valid_nxt               = 1'b1;
          end else begin
            ctl_w.clear = 1'b1;
            idx_nxt     = '0;
            state_nxt   = S_SUM_RD;
          end
        end
      end
      S_SUM_RD: begin
        cons_nxt     = 1'b1;
        cons_sum_nxt = 1'b1;
        cons_idx_nxt = idx_r;
        if (idx_r == last_w) begin
          state_nxt = S_SUM_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SUM_END: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        ctl_w.mul_en = 1'b1;
        idx_nxt      = '0;
        state_nxt    = S_PICK_RD;
      end
      S_PICK_RD: begin
        cons_nxt     = 1'b1;
        cons_sum_nxt = 1'b0;
        cons_idx_nxt = idx_r;
        if (idx_r == last_w) begin
          state_nxt = S_PICK_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_PICK_END: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_item_nxt.chosen_slot    = found_w ? 5'(chosen_idx_w) : n_w;
        out_item_nxt.best_slot      = 4'(best_idx_w);
        out_item_nxt.best_fitness   = best_fit_w;
        out_item_nxt.write_rejected = 1'b0;
        out_valid_nxt               = 1'b1;
        state_nxt                   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cons_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pop_size_r  <= 5'd10;
    end else begin
      state_r     <= state_nxt;
      cons_r      <= cons_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        pop_size_r <= cfg_data;
      end
    end
    idx_r      <= idx_nxt;
    cons_sum_r <= cons_sum_nxt;
    cons_idx_r <= cons_idx_nxt;
    frac_r     <= frac_nxt;
    out_item_r <= out_item_nxt;
  end

  rws_table #(
    .DEPTH (MAX_POPULATION),
    .IW    (IW)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we_w),
    .waddr (IW'(in_item.slot)),
    .wdata (in_item.fitness),
    .raddr (idx_r),
    .rdata (rdata_w)
  );

  rws_dp #(
    .IW (IW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl_w),
    .idx        (cons_idx_r),
    .rdata      (rdata_w),
    .frac       (frac_r),
    .found      (found_w),
    .chosen_idx (chosen_idx_w),
    .best_idx   (best_idx_w),
    .best_fit   (best_fit_w)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.func == rws_pkg::FUNC_WRITE)) |=> (out_valid && !busy))
    else $error("write item did not complete in one cycle");

  a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.func == rws_pkg::FUNC_SELECT)) |=> (busy && !out_valid))
    else $error("select item did not start a scan");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.write_rejected) |->
      ((out_item.chosen_slot == '0) && (out_item.best_fitness == '0)))
    else $error("rejected write carries nonzero fields");

  a_pass_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> ($past(state_r) == S_SUM_END))
    else $error("threshold taken before first pass ended");

endmodule

// ===== src/rws_table.sv =====
// Fitness table: one write port, one registered read port, per-entry valid bits.
// An entry never written since reset reads as -1.0. Uses rws_pkg.
module rws_table #(
  parameter int DEPTH = 16,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [IW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0]      mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [15:0]      rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rd_vld_r <= valid_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : rws_pkg::FIT_RESET;

endmodule

// ===== src/rws_dp.sv =====
// Shared accumulate/compare unit: weight sum and best tracking on the first pass,
// threshold multiply, then running sum against threshold on the second. Uses rws_pkg.
module rws_dp #(
  parameter int IW = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rws_pkg::dp_ctl_t    ctl,
  input  logic [IW-1:0]       idx,
  input  logic [15:0]         rdata,
  input  logic [15:0]         frac,
  output logic                found,
  output logic [IW-1:0]       chosen_idx,
  output logic [IW-1:0]       best_idx,
  output logic signed [15:0]  best_fit
);

  localparam int TW = 16 + IW;
  localparam int PW = 16 + TW;

  logic [TW-1:0]        total_r, total_nxt;
  logic [TW-1:0]        running_r, running_nxt;
  logic [PW-1:0]        thr_r, thr_nxt;
  logic signed [15:0]   best_fit_r, best_fit_nxt;
  logic [IW-1:0]        best_idx_r, best_idx_nxt;
  logic [IW-1:0]        chosen_idx_r, chosen_idx_nxt;
  logic                 found_r, found_nxt;
  logic [15:0]          weight_w;
  logic [TW-1:0]        sum_w;

  assign weight_w = rdata ^ rws_pkg::FIT_RESET;

  always_comb begin
    total_nxt      = total_r;
    running_nxt    = running_r;
    thr_nxt        = thr_r;
    best_fit_nxt   = best_fit_r;
    best_idx_nxt   = best_idx_r;
    chosen_idx_nxt = chosen_idx_r;
    found_nxt      = found_r;
    sum_w          = '0;
    if (ctl.clear) begin
      total_nxt   = '0;
      running_nxt = '0;
      found_nxt   = 1'b0;
    end
    if (ctl.sum_en) begin
      total_nxt = total_r + TW'(weight_w);
      if ((idx == '0) || ($signed(rdata) > best_fit_r)) begin
        best_fit_nxt = $signed(rdata);
        best_idx_nxt = idx;
      end
    end
    if (ctl.mul_en) begin
      thr_nxt = PW'(frac) * PW'(total_r);
    end
    if (ctl.pick_en) begin
      sum_w       = running_r + TW'(weight_w);
      running_nxt = sum_w;
      if (!found_r && ({sum_w, 16'h0000} > thr_r)) begin
        found_nxt      = 1'b1;
        chosen_idx_nxt = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    total_r      <= total_nxt;
    running_r    <= running_nxt;
    thr_r        <= thr_nxt;
    best_fit_r   <= best_fit_nxt;
    best_idx_r   <= best_idx_nxt;
    chosen_idx_r <= chosen_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  assign found      = found_r;
  assign chosen_idx = chosen_idx_r;
  assign best_idx   = best_idx_r;
  assign best_fit   = best_fit_r;

endmodule

// ===== sim/roulette_wheel_selection_test.sv =====
// Testbench for roulette_wheel_selection: directed and random write/select items
// checked against an in-bench fitness table predictor. Depends on rws_pkg and the
// block itself; needs no files or arguments.
`timescale 1ns / 100ps

module roulette_wheel_selection_test;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  rws_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  rws_pkg::out_item_t out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [4:0]         cfg_data = '0;

  logic [15:0]        fit_model [16];
  logic [4:0]         pop_model;
  rws_pkg::out_item_t pending_results[$];
  int          sender_idle_pct = 0;
  int          mismatches = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          n_selects = 0;
  int          n_rejects = 0;

  roulette_wheel_selection i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("roulette_wheel_selection_test: errors");
    $finish;
  end

  function automatic int active_slots();
    if (pop_model == 0) return 1;
    if (pop_model > 16) return 16;
    return int'(pop_model);
  endfunction

  // Apply one item to the table copy and return the result it must produce.
  function automatic rws_pkg::out_item_t wheel_predict(input rws_pkg::in_item_t it);
    rws_pkg::out_item_t r;
    int               n;
    int               best;
    int               chosen;
    logic signed [15:0] best_val;
    longint unsigned  total;
    longint unsigned  running;
    longint unsigned  threshold;
    n = active_slots();
    r = '0;
    if (it.func == rws_pkg::FUNC_WRITE) begin
      if (int'(it.slot) < n) begin
        fit_model[it.slot] = it.fitness;
      end else begin
        r.write_rejected = 1'b1;
      end
      return r;
    end
    total = 0;
    best = 0;
    best_val = $signed(fit_model[0]);
    for (int i = 0; i < n; i++) begin
      total += {48'd0, ~fit_model[i][15], fit_model[i][14:0]};
      if ($signed(fit_model[i]) > best_val) begin
        best_val = $signed(fit_model[i]);
        best = i;
      end
    end
    threshold = longint'(it.rand_fraction) * total;
    running = 0;
    chosen = n;
    for (int i = 0; i < n; i++) begin
      running += {48'd0, ~fit_model[i][15], fit_model[i][14:0]};
      if ((running << 16) > threshold) begin
        chosen = i;
        break;
      end
    end
    r.chosen_slot = 5'(chosen);
    r.best_slot = 4'(best);
    r.best_fitness = fit_model[best];
    return r;
  endfunction

  always @(posedge clk) begin
    rws_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: chosen=%0d best=%0d fit=%0d rej=%0b",
                   $time, out_item.chosen_slot, out_item.best_slot,
                   out_item.best_fitness, out_item.write_rejected);
      end else begin
        want = pending_results.pop_front();
        if (out_item.chosen_slot !== want.chosen_slot ||
            out_item.best_slot !== want.best_slot ||
            out_item.best_fitness !== want.best_fitness ||
            out_item.write_rejected !== want.write_rejected) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: mismatch: exp chosen=%0d best=%0d fit=%0d rej=%0b,",
                      " got chosen=%0d best=%0d fit=%0d rej=%0b"},
                     $time, want.chosen_slot, want.best_slot, want.best_fitness,
                     want.write_rejected, out_item.chosen_slot, out_item.best_slot,
                     out_item.best_fitness, out_item.write_rejected);
        end
      end
    end
  end

  // Leave start high after accept unless idling, so the next call can follow at once.
  task automatic send_item(input rws_pkg::in_item_t it);
    rws_pkg::out_item_t r;
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = wheel_predict(it);
    pending_results.push_back(r);
    n_items++;
    if (it.func == rws_pkg::FUNC_SELECT) n_selects++;
    if (r.write_rejected) n_rejects++;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_pop_size(input logic [4:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pop_model = v;
    @(posedge clk);
  endtask

  task automatic write_fit(input logic [3:0] slot, input logic signed [15:0] fit);
    rws_pkg::in_item_t it;
    it.func = rws_pkg::FUNC_WRITE;
    it.slot = slot;
    it.fitness = fit;
    it.rand_fraction = 16'($urandom);
    send_item(it);
  endtask

  task automatic spin(input logic [15:0] frac);
    rws_pkg::in_item_t it;
    it.func = rws_pkg::FUNC_SELECT;
    it.slot = 4'($urandom);
    it.fitness = 16'($urandom);
    it.rand_fraction = frac;
    send_item(it);
  endtask

  task automatic test_cleared_table();
    spin(16'h0000);
    spin(16'hFFFF);
  endtask

  task automatic test_table_writes();
    write_fit(4'd0, 16'sh7FFF);
    write_fit(4'd9, -16'sd32768);
    write_fit(4'd10, 16'sd1234);
    write_fit(4'd15, -16'sd1);
    spin(16'h0000);
    spin(16'hFFFF);
    write_fit(4'd3, 16'sh5555);
    write_fit(4'd5, 16'sh5555);
    write_fit(4'd0, 16'sd0);
    spin(16'h8000);
    write_fit(4'd7, 16'shAAAA);
    spin(16'h0001);
  endtask

  task automatic test_pop_limits();
    drain_results();
    set_pop_size(5'd0);
    write_fit(4'd1, 16'sd100);
    write_fit(4'd0, -16'sd32768);
    spin(16'hFFFF);
    drain_results();
    set_pop_size(5'd16);
    write_fit(4'd15, 16'sh7FFF);
    spin(16'hFFFF);
    drain_results();
    set_pop_size(5'd31);
    write_fit(4'd15, 16'sd0);
    spin(16'h0000);
    drain_results();
    set_pop_size(5'd17);
    spin(16'h8000);
  endtask

  // Mostly writes into active slots interleaved with spins; pause once mid-phase.
  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input logic [4:0] pop);
    rws_pkg::in_item_t it;
    drain_results();
    set_pop_size(pop);
    sender_idle_pct = idle_pct;
    for (int k = 0; k < count; k++) begin
      it.func = ($urandom_range(99) < 35) ? rws_pkg::FUNC_SELECT : rws_pkg::FUNC_WRITE;
      if ($urandom_range(99) < 85)
        it.slot = 4'($urandom_range(active_slots() - 1));
      else
        it.slot = 4'($urandom_range(15));
      case ($urandom_range(7))
        0: it.fitness = 16'sh7FFF;
        1: it.fitness = -16'sd32768;
        default: it.fitness = 16'($urandom);
      endcase
      case ($urandom_range(7))
        0: it.rand_fraction = 16'h0000;
        1: it.rand_fraction = 16'hFFFF;
        default: it.rand_fraction = 16'($urandom);
      endcase
      send_item(it);
      if (k == count / 2) drain_results();
    end
    drain_results();
    sender_idle_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < 16; i++) fit_model[i] = rws_pkg::FIT_RESET;
    pop_model = 5'd10;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cleared_table();
    test_table_writes();
    test_pop_limits();
    test_random_traffic(135, 22, 5'($urandom_range(2, 16)));
    test_random_traffic(135, 85, 5'd16);
    test_random_traffic(130, 0, 5'($urandom_range(0, 31)));
    $display("covered %0d items (%0d spins, %0d rejected writes), %0d results checked",
             n_items, n_selects, n_rejects, n_results);
    $display("population sizes 0, 16, 17 and 31 plus random; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("roulette_wheel_selection_test: clean");
    end else begin
      $display("roulette_wheel_selection_test: errors");
    end
    $finish;
  end

endmodule
